### rtl/pws_pkg.sv
`default_nettype none

package pws_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RAD_W  = 31;
  localparam int unsigned HALF_W = 16;

  // Stencil operand: widest is the one-sided edge sum, |x| <= 2^34
  localparam int unsigned OPA_W  = 36;
  // Split partial product: operand times a 16-bit half of a coefficient
  localparam int unsigned PART_W = OPA_W + HALF_W + 1;
  // Full product: operand times a 32-bit coefficient, with headroom
  localparam int unsigned PROD_W = 69;

  // Interior terms are clamped to +-(2^38 - 1)
  localparam int unsigned QBITS  = 38;
  localparam int unsigned WIDE_W = QBITS + 1;

  localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(64'sd274877906943);
  localparam logic signed [PROD_W-1:0] WIDE_MIN = -WIDE_MAX;
  localparam logic signed [PROD_W-1:0] WORD_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] WORD_MIN = -WORD_MAX - PROD_W'(1);

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    KIND_GHOST    = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_EDGE     = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_DX_SQ  = 2'd0,
    REG_INV_TWO_DX = 2'd1,
    REG_INV_DY_SQ  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                     hit;
    logic signed [WIDE_W-1:0] val;
  } wide_res_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] val;
  } word_res_t;

  // Per-point data that rides alongside the radial dividers
  typedef struct packed {
    logic                     is_int;
    logic                     rzero;
    logic                     ovf;
    logic signed [DATA_W-1:0] dphi;
    logic signed [DATA_W-1:0] dpi_edge;
    logic signed [WIDE_W-1:0] t1;
  } front_side_t;

  typedef struct packed {
    front_side_t              front;
    logic signed [WIDE_W-1:0] t2;
  } divb_side_t;

  // Clamp a wide value to the interior term range
  function automatic wide_res_t clamp_wide(input logic signed [PROD_W-1:0] v);
    wide_res_t res;
    res.hit = 1'b0;
    if (v > WIDE_MAX) begin
      res.hit = 1'b1;
      res.val = WIDE_W'(WIDE_MAX);
    end else if (v < WIDE_MIN) begin
      res.hit = 1'b1;
      res.val = WIDE_W'(WIDE_MIN);
    end else begin
      res.val = WIDE_W'(v);
    end
    return res;
  endfunction

  // Saturate a wide value to a signed 32-bit word
  function automatic word_res_t sat_word(input logic signed [PROD_W-1:0] v);
    word_res_t res;
    res.hit = 1'b0;
    if (v > WORD_MAX) begin
      res.hit = 1'b1;
      res.val = DATA_W'(WORD_MAX);
    end else if (v < WORD_MIN) begin
      res.hit = 1'b1;
      res.val = DATA_W'(WORD_MIN);
    end else begin
      res.val = DATA_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/pws_mul_lane.sv
`default_nettype none

// Two-stage signed-by-unsigned fixed-point multiplier:
// split partial products, then recombine and drop the fraction bits (floor).
module pws_mul_lane import pws_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire logic signed [OPA_W-1:0]  a_i,
  input  wire logic [DATA_W-1:0]        b_i,
  output logic signed [PROD_W-1:0]      prod_o
);

  logic signed [PART_W-1:0] lo_q;
  logic signed [PART_W-1:0] hi_q;
  logic signed [PROD_W-1:0] prod_q;

  // Partial products against each coefficient half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= a_i * $signed({1'b0, b_i[HALF_W-1:0]});
      hi_q <= a_i * $signed({1'b0, b_i[DATA_W-1:HALF_W]});
    end
  end

  // Recombine and shift with rounding toward minus infinity
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ((PROD_W'(hi_q) <<< HALF_W) + PROD_W'(lo_q)) >>> FRAC_BITS;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/pws_front.sv
`default_nettype none

// Front end: stencil differences, three coefficient products, clamping.
// Four register stages; lanes are shared between interior and edge points.
module pws_front import pws_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire                         vld_i,
  input  wire logic [1:0]             func_i,
  input  wire logic signed [DATA_W-1:0] phi_centre_i,
  input  wire logic signed [DATA_W-1:0] phi_east_i,
  input  wire logic signed [DATA_W-1:0] phi_west_i,
  input  wire logic signed [DATA_W-1:0] phi_north_i,
  input  wire logic signed [DATA_W-1:0] phi_south_i,
  input  wire logic signed [DATA_W-1:0] phi_near_i,
  input  wire logic signed [DATA_W-1:0] phi_far_i,
  input  wire logic signed [DATA_W-1:0] pi_centre_i,
  input  wire logic signed [DATA_W-1:0] pi_near_i,
  input  wire logic signed [DATA_W-1:0] pi_far_i,
  input  wire logic [RAD_W-1:0]       radius_i,
  input  wire logic [DATA_W-1:0]      inv_dx_sq_i,
  input  wire logic [DATA_W-1:0]      inv_two_dx_i,
  input  wire logic [DATA_W-1:0]      inv_dy_sq_i,
  output logic                        vld_o,
  output front_side_t                 side_o,
  output logic signed [WIDE_W-1:0]    t2_o,
  output logic signed [WIDE_W-1:0]    t3_o,
  output logic [RAD_W-1:0]            r_o
);

  localparam int unsigned LANES = 3;
  localparam int unsigned LN_A  = 0;
  localparam int unsigned LN_B  = 1;
  localparam int unsigned LN_C  = 2;

  typedef struct packed {
    logic                     is_int;
    logic                     is_edge;
    logic                     rzero;
    logic [RAD_W-1:0]         r;
    logic signed [DATA_W-1:0] pic;
  } mid_t;

  logic                    is_int_c;
  logic                    is_edge_c;
  logic signed [OPA_W-1:0] d2r_c;
  logic signed [OPA_W-1:0] d1r_c;
  logic signed [OPA_W-1:0] d2y_c;
  logic signed [OPA_W-1:0] ephi_c;
  logic signed [OPA_W-1:0] epi_c;

  logic                    vld1_q, vld2_q, vld3_q, vld4_q;
  mid_t                    mid1_q, mid2_q, mid3_q;
  logic signed [OPA_W-1:0] opa_q [LANES];
  logic [DATA_W-1:0]       bc_q;
  logic [DATA_W-1:0]       coef [LANES];
  logic signed [PROD_W-1:0] prod [LANES];

  wide_res_t               ca, cb, cc;
  word_res_t               sb, sc;
  front_side_t             side_d, side_q;
  logic signed [WIDE_W-1:0] t2_q, t3_q;
  logic [RAD_W-1:0]        r4_q;

  // Stencil differences
  always_comb begin
    is_int_c  = (func_i == KIND_INTERIOR);
    is_edge_c = (func_i == KIND_EDGE);
    d2r_c  = OPA_W'(phi_east_i) - (OPA_W'(phi_centre_i) <<< 1) + OPA_W'(phi_west_i);
    d1r_c  = OPA_W'(phi_east_i) - OPA_W'(phi_west_i);
    d2y_c  = OPA_W'(phi_north_i) - (OPA_W'(phi_centre_i) <<< 1) + OPA_W'(phi_south_i);
    ephi_c = (OPA_W'(phi_near_i) <<< 2) - (OPA_W'(phi_centre_i) <<< 1)
           - OPA_W'(phi_centre_i) - OPA_W'(phi_far_i);
    epi_c  = (OPA_W'(pi_near_i) <<< 2) - (OPA_W'(pi_centre_i) <<< 1)
           - OPA_W'(pi_centre_i) - OPA_W'(pi_far_i);
  end

  // Stage 1: register operands, pick lane roles by point kind
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q[LN_A]   <= d2r_c;
      opa_q[LN_B]   <= is_int_c ? d1r_c : ephi_c;
      opa_q[LN_C]   <= is_int_c ? d2y_c : epi_c;
      bc_q          <= is_int_c ? inv_dy_sq_i : inv_two_dx_i;
      mid1_q.is_int  <= is_int_c;
      mid1_q.is_edge <= is_edge_c;
      mid1_q.rzero   <= (radius_i == '0);
      mid1_q.r       <= radius_i;
      mid1_q.pic     <= pi_centre_i;
    end
  end

  // Stages 2 and 3: multipliers
  assign coef[LN_A] = inv_dx_sq_i;
  assign coef[LN_B] = inv_two_dx_i;
  assign coef[LN_C] = bc_q;

  for (genvar l = 0; l < LANES; l++) begin : g_mul
    pws_mul_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (opa_q[l]),
      .b_i   (coef[l]),
      .prod_o(prod[l])
    );
  end

  // Carry point data beside the multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid2_q <= mid1_q;
      mid3_q <= mid2_q;
    end
  end

  // Stage 4: clamp interior terms, saturate edge results
  always_comb begin
    ca = clamp_wide(prod[LN_A]);
    cb = clamp_wide(prod[LN_B]);
    cc = clamp_wide(prod[LN_C]);
    sb = sat_word(prod[LN_B]);
    sc = sat_word(prod[LN_C]);
    side_d.is_int   = mid3_q.is_int;
    side_d.rzero    = mid3_q.rzero;
    side_d.t1       = ca.val;
    side_d.dpi_edge = mid3_q.is_edge ? sc.val : '0;
    if (mid3_q.is_int) begin
      side_d.ovf  = ca.hit | cb.hit | cc.hit | mid3_q.rzero;
      side_d.dphi = mid3_q.pic;
    end else if (mid3_q.is_edge) begin
      side_d.ovf  = sb.hit | sc.hit;
      side_d.dphi = sb.val;
    end else begin
      side_d.ovf  = 1'b0;
      side_d.dphi = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      t2_q   <= cb.val;
      t3_q   <= cc.val;
      r4_q   <= mid3_q.r;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  assign vld_o  = vld4_q;
  assign side_o = side_q;
  assign t2_o   = t2_q;
  assign t3_o   = t3_q;
  assign r_o    = r4_q;

endmodule

`default_nettype wire

### rtl/pws_div_pipe.sv
`default_nettype none

// Pipelined signed division by the radius: t * 2^FRAC_BITS / r, truncated
// toward zero, clamped to +-(2^38 - 1). One quotient bit per stage on
// magnitudes; a prep stage, QBITS step stages and a sign/clamp stage.
module pws_div_pipe import pws_pkg::*; #(
  parameter int unsigned LANES     = 1,
  parameter int unsigned SB_W      = 1,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          vld_i,
  input  wire logic [RAD_W-1:0]        r_i,
  input  wire logic signed [WIDE_W-1:0] t_i [LANES],
  input  wire logic [SB_W-1:0]         side_i,
  output logic                         vld_o,
  output logic [RAD_W-1:0]             r_o,
  output logic signed [WIDE_W-1:0]     q_o [LANES],
  output logic [LANES-1:0]             clamp_o,
  output logic [SB_W-1:0]              side_o
);

  localparam int unsigned REM_W = RAD_W;
  localparam int unsigned SHIFT = QBITS - FRAC_BITS;

  logic [QBITS-1:0] mag_c  [LANES];
  logic             neg_c  [LANES];
  logic             big_c  [LANES];
  logic [REM_W-1:0] rem0_c [LANES];
  logic [QBITS-1:0] x0_c   [LANES];

  logic             vld_q  [QBITS+1];
  logic [RAD_W-1:0] r_q    [QBITS+1];
  logic [SB_W-1:0]  side_q [QBITS+1];
  logic [REM_W-1:0] rem_q  [QBITS+1][LANES];
  logic [QBITS-1:0] x_q    [QBITS+1][LANES];
  logic             neg_q  [QBITS+1][LANES];
  logic             big_q  [QBITS+1][LANES];

  logic signed [WIDE_W-1:0] qs_c [LANES];
  logic signed [WIDE_W-1:0] q_q  [LANES];
  logic [LANES-1:0]         clamp_q;
  logic                     vld_out_q;
  logic [RAD_W-1:0]         r_out_q;
  logic [SB_W-1:0]          side_out_q;

  // Prep: magnitude, sign, and the quotient-too-large test
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_c[l]  = t_i[l][WIDE_W-1];
      mag_c[l]  = QBITS'(neg_c[l] ? -t_i[l] : t_i[l]);
      big_c[l]  = (mag_c[l] >> SHIFT) >= QBITS'(r_i);
      rem0_c[l] = REM_W'(mag_c[l] >> SHIFT);
      x0_c[l]   = QBITS'(mag_c[l] << FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= r_i;
      side_q[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= rem0_c[l];
        x_q[0][l]   <= x0_c[l];
        neg_q[0][l] <= neg_c[l];
        big_q[0][l] <= big_c[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  // Restoring division steps: shift in one dividend bit, subtract if it fits
  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      logic           ge;

      assign trial = {rem_q[k-1][l], x_q[k-1][l][QBITS-1]};
      assign diff  = trial - {1'b0, r_q[k-1]};
      assign ge    = (trial >= {1'b0, r_q[k-1]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
          x_q[k][l]   <= {x_q[k-1][l][QBITS-2:0], ge};
          neg_q[k][l] <= neg_q[k-1][l];
          big_q[k][l] <= big_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Clamp oversized quotients, restore the sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (big_q[QBITS][l]) begin
        qs_c[l] = neg_q[QBITS][l] ? WIDE_W'(WIDE_MIN) : WIDE_W'(WIDE_MAX);
      end else if (neg_q[QBITS][l]) begin
        qs_c[l] = -$signed({1'b0, x_q[QBITS][l]});
      end else begin
        qs_c[l] = $signed({1'b0, x_q[QBITS][l]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_out_q    <= r_q[QBITS];
      side_out_q <= side_q[QBITS];
      for (int l = 0; l < LANES; l++) begin
        q_q[l]     <= qs_c[l];
        clamp_q[l] <= big_q[QBITS][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[QBITS];
    end
  end

  assign vld_o   = vld_out_q;
  assign r_o     = r_out_q;
  assign q_o     = q_q;
  assign clamp_o = clamp_q;
  assign side_o  = side_out_q;

  // After the first step, lane 0's partial remainder is below the divisor when no clamp was flagged
  a_rem_below_r: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !big_q[1][0] |-> rem_q[1][0] < r_q[1])
    else $error("divider remainder not below radius");

endmodule

`default_nettype wire

### rtl/polar_wave_rhs_stencil_core.sv
`default_nettype none

// Polar wave-equation right-hand side, one grid point per request.
// Throughput is one point per cycle unless stalled. A point passes through
// 4 front-end stages (differences, split multiply, clamp),
// two 40-stage radial dividers in series (one quotient bit per stage, the
// second division by radius for the angular term follows the first), one
// sum/saturate stage and the output register. s_axis_tready drops only while
// the output skid entry is occupied, and every stage then holds. Ghost and
// unused point kinds return zeros without the overflow flag; a zero radius
// on an interior point drops both radius terms and raises the flag.
// Configuration writes are always taken and should be made while idle.
module polar_wave_rhs_stencil_core import pws_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Point requests
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // phi_centre, phi_east, phi_west, phi_north, phi_south, phi_near,
  // phi_far, pi_centre, pi_near, pi_far (32 each), radius (31), pad (1)
  input  wire logic [351:0]    s_axis_tdata,
  // func (2)
  input  wire logic [1:0]      s_axis_tuser,
  // Results
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // dphi_dt (32), dpi_dt (32)
  output logic [63:0]          m_axis_tdata,
  // overflow (1)
  output logic                 m_axis_tuser,
  // Configuration writes
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  localparam logic [DATA_W-1:0] ONE_Q  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] HALF_Q = DATA_W'(64'd1 << (FRAC_BITS - 1));
  localparam int unsigned       RAD_LO = 10 * DATA_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] dphi;
    logic signed [DATA_W-1:0] dpi;
    logic                     ovf;
  } res_t;

  logic [DATA_W-1:0] inv_dx_sq_q, inv_two_dx_q, inv_dy_sq_q;

  logic                     en;
  logic                     vld_f;
  front_side_t              side_f;
  logic signed [WIDE_W-1:0] t2_f, t3_f;
  logic [RAD_W-1:0]         r_f;

  logic signed [WIDE_W-1:0] ta [2];
  logic signed [WIDE_W-1:0] qa [2];
  logic [1:0]               clamp_a;
  logic                     vld_a;
  logic [RAD_W-1:0]         r_a;
  logic [$bits(front_side_t)-1:0] side_a_vec;
  front_side_t              side_a;

  divb_side_t               side_bi;
  logic signed [WIDE_W-1:0] tb [1];
  logic signed [WIDE_W-1:0] qb [1];
  logic [0:0]               clamp_b;
  logic                     vld_b;
  logic [$bits(divb_side_t)-1:0] side_b_vec;
  divb_side_t               side_b;

  logic signed [WIDE_W-1:0] t2m, t3m;
  word_res_t                sum_sat;
  res_t                     fin_d, fin_q;
  logic                     fin_vld_q;

  res_t                     out_q, skid_q;
  logic                     out_vld_q, skid_vld_q;
  logic                     push, pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dx_sq_q  <= ONE_Q;
      inv_two_dx_q <= HALF_Q;
      inv_dy_sq_q  <= ONE_Q;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INV_DX_SQ:  inv_dx_sq_q  <= cfg_data_i;
        REG_INV_TWO_DX: inv_two_dx_q <= cfg_data_i;
        REG_INV_DY_SQ:  inv_dy_sq_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances while the skid entry is free
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  pws_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (s_axis_tvalid),
    .func_i      (s_axis_tuser),
    .phi_centre_i(s_axis_tdata[0*DATA_W +: DATA_W]),
    .phi_east_i  (s_axis_tdata[1*DATA_W +: DATA_W]),
    .phi_west_i  (s_axis_tdata[2*DATA_W +: DATA_W]),
    .phi_north_i (s_axis_tdata[3*DATA_W +: DATA_W]),
    .phi_south_i (s_axis_tdata[4*DATA_W +: DATA_W]),
    .phi_near_i  (s_axis_tdata[5*DATA_W +: DATA_W]),
    .phi_far_i   (s_axis_tdata[6*DATA_W +: DATA_W]),
    .pi_centre_i (s_axis_tdata[7*DATA_W +: DATA_W]),
    .pi_near_i   (s_axis_tdata[8*DATA_W +: DATA_W]),
    .pi_far_i    (s_axis_tdata[9*DATA_W +: DATA_W]),
    .radius_i    (s_axis_tdata[RAD_LO +: RAD_W]),
    .inv_dx_sq_i (inv_dx_sq_q),
    .inv_two_dx_i(inv_two_dx_q),
    .inv_dy_sq_i (inv_dy_sq_q),
    .vld_o       (vld_f),
    .side_o      (side_f),
    .t2_o        (t2_f),
    .t3_o        (t3_f),
    .r_o         (r_f)
  );

  // First division by radius: radial term and angular term together
  assign ta[0] = t2_f;
  assign ta[1] = t3_f;

  pws_div_pipe #(
    .LANES    (2),
    .SB_W     ($bits(front_side_t)),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_f),
    .r_i    (r_f),
    .t_i    (ta),
    .side_i (side_f),
    .vld_o  (vld_a),
    .r_o    (r_a),
    .q_o    (qa),
    .clamp_o(clamp_a),
    .side_o (side_a_vec)
  );

  assign side_a = side_a_vec;

  // Fold first-division clamps into the flag, second division of the angular term
  always_comb begin
    side_bi.front     = side_a;
    side_bi.front.ovf = side_a.ovf
                      | (side_a.is_int & !side_a.rzero & (|clamp_a));
    side_bi.t2        = qa[0];
  end

  assign tb[0] = qa[1];

  pws_div_pipe #(
    .LANES    (1),
    .SB_W     ($bits(divb_side_t)),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_a),
    .r_i    (r_a),
    .t_i    (tb),
    .side_i (side_bi),
    .vld_o  (vld_b),
    .r_o    (),
    .q_o    (qb),
    .clamp_o(clamp_b),
    .side_o (side_b_vec)
  );

  assign side_b = side_b_vec;

  // Sum interior terms, saturate, select by point kind
  always_comb begin
    t2m     = side_b.front.rzero ? '0 : side_b.t2;
    t3m     = side_b.front.rzero ? '0 : qb[0];
    sum_sat = sat_word(PROD_W'(side_b.front.t1) + PROD_W'(t2m) + PROD_W'(t3m));
    fin_d.dphi = side_b.front.dphi;
    if (side_b.front.is_int) begin
      fin_d.dpi = sum_sat.val;
      fin_d.ovf = side_b.front.ovf | sum_sat.hit
                | (!side_b.front.rzero & clamp_b[0]);
    end else begin
      fin_d.dpi = side_b.front.dpi_edge;
      fin_d.ovf = side_b.front.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (en) begin
      fin_vld_q <= vld_b;
    end
  end

  // Output register with one skid entry
  assign push = fin_vld_q && en;
  assign pop  = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= fin_q;
      end else begin
        out_q <= fin_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.dpi, out_q.dphi};
  assign m_axis_tuser  = out_q.ovf;

  // Skid entry is only ever held behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty output register");

  // Skid fills only when a result met a stalled, full output register
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready && fin_vld_q))
    else $error("skid entry filled without a stall");

  // Interior point at zero radius always carries the overflow flag
  a_rzero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_b && side_b.front.is_int && side_b.front.rzero |-> side_b.front.ovf)
    else $error("zero radius on interior point without overflow flag");

endmodule

`default_nettype wire
